[design/tbp_pkg.sv]
// Shared types, constants and helpers for the tiled 4bpp square brush plotter.
package tbp_pkg;

    localparam int MAX_BRUSH     = 32;
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 192;
    localparam int NUM_BUFFERS   = 4;
    localparam int TILES_PER_ROW = 32;
    localparam int BUF_WORDS     = TILES_PER_ROW * ((SCREEN_HEIGHT + 7) / 8) * 8;
    localparam int MEM_DEPTH     = NUM_BUFFERS * BUF_WORDS;

    localparam int WORD_W   = 32;
    localparam int ADDR_W   = $clog2(MEM_DEPTH);
    localparam int COORD_W  = 11;
    localparam int POS_W    = 12;
    localparam int COLOR_W  = 4;
    localparam int SIZE_W   = 6;
    localparam int STEP_W   = 5;
    localparam int RBUF_W   = 2;
    localparam int WIDX_W   = 13;
    localparam int COUNT_W  = 11;
    localparam int TGT_W    = 3;

    typedef enum logic
    {
        CMD_DRAW = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic
    {
        KIND_DRAW_DONE = 1'b0,
        KIND_READ_DATA = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_FINISH
    } state_t;

    // One pixel visit handed to the shared address and merge unit
    typedef struct packed
    {
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] y0;
        logic [STEP_W-1:0]       col;
        logic [STEP_W-1:0]       row;
        logic [RBUF_W-1:0]       bsel;
        logic [COLOR_W-1:0]      color;
    } pix_req_t;

    typedef struct packed
    {
        logic              on_screen;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } pix_rsp_t;

    function automatic logic [ADDR_W-1:0] buf_base(input logic [RBUF_W-1:0] b);
        buf_base = ADDR_W'(b) * ADDR_W'(BUF_WORDS);
    endfunction

endpackage

[design/tbp_if.sv]
// Request, result and configuration channel interfaces.
interface tbp_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [tbp_pkg::COORD_W-1:0] center_x;
    logic signed [tbp_pkg::COORD_W-1:0] center_y;
    logic [tbp_pkg::COLOR_W-1:0]       color;
    logic [tbp_pkg::SIZE_W-1:0]        brush_size;
    logic [tbp_pkg::RBUF_W-1:0]        read_buffer;
    logic [tbp_pkg::WIDX_W-1:0]        read_word_index;

    modport source (output valid, command, center_x, center_y, color, brush_size,
                    read_buffer, read_word_index, input ready);
    modport sink   (input valid, command, center_x, center_y, color, brush_size,
                    read_buffer, read_word_index, output ready);
endinterface

interface tbp_res_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [tbp_pkg::WORD_W-1:0]   read_data;
    logic [tbp_pkg::COUNT_W-1:0]  pixels_drawn;

    modport source (output valid, result_kind, read_data, pixels_drawn, input ready);
    modport sink   (input valid, result_kind, read_data, pixels_drawn, output ready);
endinterface

interface tbp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tbp_pkg::TGT_W-1:0]  target_buffer;

    modport source (output valid, target_buffer, input ready);
    modport sink   (input valid, target_buffer, output ready);
endinterface

[design/tbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tbp_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/tbp_pix.sv]
// Shared pixel unit: clip test, tiled word address and nibble merge.
module tbp_pix (
    input  tbp_pkg::pix_req_t            req,
    input  logic [tbp_pkg::WORD_W-1:0]   rdata,
    output tbp_pkg::pix_rsp_t            rsp
);
    import tbp_pkg::*;

    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [WIDX_W-1:0]       widx;
    logic [WORD_W-1:0]       mask;
    logic [WORD_W-1:0]       fill;

    always_comb
    begin
        x = req.x0 + POS_W'(req.col);
        y = req.y0 + POS_W'(req.row);
        rsp.on_screen = !x[POS_W-1] && (x[POS_W-2:0] < (POS_W-1)'(SCREEN_WIDTH))
                     && !y[POS_W-1] && (y[POS_W-2:0] < (POS_W-1)'(SCREEN_HEIGHT));
        // tile row, tile column, then row within tile
        widx = {y[7:3], x[7:3], y[2:0]};
        rsp.addr = buf_base(req.bsel) + ADDR_W'(widx);
        mask = WORD_W'(4'hf) << {x[2:0], 2'b00};
        fill = WORD_W'(req.color) << {x[2:0], 2'b00};
        rsp.wdata = (rdata & ~mask) | fill;
    end

endmodule

[design/tbp_ctrl.sv]
// Sequencer: clearing pass, command decode, pixel walk and result register.
module tbp_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    tbp_cmd_if.sink                    cmd,
    tbp_res_if.source                  res,
    tbp_cfg_if.sink                    cfg,
    output tbp_pkg::pix_req_t          pix_req,
    input  tbp_pkg::pix_rsp_t          pix_rsp,
    input  logic [tbp_pkg::WORD_W-1:0] mem_rdata,
    output logic                       mem_we,
    output logic [tbp_pkg::ADDR_W-1:0] mem_waddr,
    output logic [tbp_pkg::WORD_W-1:0] mem_wdata,
    output logic [tbp_pkg::ADDR_W-1:0] mem_raddr
);
    import tbp_pkg::*;

    state_t                  state_reg, state_next;
    logic [TGT_W-1:0]        target_reg;
    logic [ADDR_W-1:0]       clr_reg;
    logic [STEP_W-1:0]       col_reg;
    logic [STEP_W-1:0]       row_reg;
    logic [SIZE_W-1:0]       n_reg;
    logic signed [POS_W-1:0] x0_reg;
    logic signed [POS_W-1:0] y0_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic [COUNT_W-1:0]      cnt_reg;
    logic [WORD_W-1:0]       data_reg;
    logic                    kind_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic                    rd_ok_reg;
    logic                    res_valid_reg;
    logic                    res_kind_reg;
    logic [WORD_W-1:0]       res_data_reg;
    logic [COUNT_W-1:0]      res_cnt_reg;

    logic                    accept;
    logic                    col_last;
    logic                    row_last;
    logic                    walk_last;
    logic                    slot_free;
    logic                    draw_skip;
    logic [SIZE_W-1:0]       n_sat;
    logic [STEP_W-1:0]       half;

    assign accept    = cmd.valid && cmd.ready;
    assign col_last  = ({1'b0, col_reg} == n_reg - SIZE_W'(1));
    assign row_last  = ({1'b0, row_reg} == n_reg - SIZE_W'(1));
    assign walk_last = col_last && row_last;
    assign slot_free = !res_valid_reg || res.ready;
    assign n_sat     = (cmd.brush_size > SIZE_W'(MAX_BRUSH)) ? SIZE_W'(MAX_BRUSH)
                                                             : cmd.brush_size;
    assign half      = n_sat[SIZE_W-1:1];
    assign draw_skip = (n_sat == '0) || (target_reg >= TGT_W'(NUM_BUFFERS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.command == CMD_READ)
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else if (draw_skip)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PIX_RD;
                    end
                end
            end
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_FINISH;
            ST_PIX_RD:
            begin
                if (pix_rsp.on_screen)
                begin
                    state_next = ST_PIX_WR;
                end
                else if (walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PIX_WR:  state_next = walk_last ? ST_FINISH : ST_PIX_RD;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pix_rsp.addr;
        mem_wdata = pix_rsp.wdata;
        mem_raddr = pix_rsp.addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:    cmd.ready = 1'b1;
            ST_RD_ADDR: mem_raddr = rd_addr_reg;
            ST_PIX_WR:  mem_we    = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign cfg.ready        = 1'b1;
    assign res.valid        = res_valid_reg;
    assign res.result_kind  = res_kind_reg;
    assign res.read_data    = res_data_reg;
    assign res.pixels_drawn = res_cnt_reg;

    assign pix_req.x0    = x0_reg;
    assign pix_req.y0    = y0_reg;
    assign pix_req.col   = col_reg;
    assign pix_req.row   = row_reg;
    assign pix_req.bsel  = target_reg[RBUF_W-1:0];
    assign pix_req.color = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            target_reg    <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                target_reg <= cfg.target_buffer;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == ST_FINISH && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_reg    <= cmd.command;
                    cnt_reg     <= '0;
                    data_reg    <= '0;
                    col_reg     <= '0;
                    row_reg     <= '0;
                    n_reg       <= n_sat;
                    color_reg   <= cmd.color;
                    x0_reg      <= POS_W'(cmd.center_x) - POS_W'(half);
                    y0_reg      <= POS_W'(cmd.center_y) - POS_W'(half);
                    rd_addr_reg <= buf_base(cmd.read_buffer) + ADDR_W'(cmd.read_word_index);
                    rd_ok_reg   <= (cmd.read_word_index < WIDX_W'(BUF_WORDS))
                                && ({1'b0, cmd.read_buffer} < (RBUF_W+1)'(NUM_BUFFERS));
                end
            end
            ST_RD_DATA:
            begin
                data_reg <= rd_ok_reg ? mem_rdata : '0;
            end
            ST_PIX_RD, ST_PIX_WR:
            begin
                if (state_reg == ST_PIX_WR)
                begin
                    cnt_reg <= cnt_reg + COUNT_W'(1);
                end
                // advance to the next pixel once this one is done or clipped
                if (state_reg == ST_PIX_WR || !pix_rsp.on_screen)
                begin
                    if (col_last)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + STEP_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + STEP_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    res_kind_reg <= kind_reg;
                    res_data_reg <= data_reg;
                    res_cnt_reg  <= cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[design/tiled_4bpp_square_brush_plot_top.sv]
// Top level of the tiled 4bpp square brush plotter.
// After reset the block clears all four character buffers, one word per cycle;
// requests wait until that pass ends, configuration writes are taken throughout.
// Requests are handled one at a time through a buffer RAM with one write and one
// read port and one shared pixel address and merge unit. A draw of side n
// (saturated to 32) walks the n*n square: each on-screen pixel gets a word read,
// then a merged write, and each clipped pixel gets no write; a drawing to a
// suppressed buffer or of size zero skips the walk. Results leave through an
// output register, so the result is held while the next request is accepted.
module tiled_4bpp_square_brush_plot_top (
    input  logic      clk,
    input  logic      rst_n,
    tbp_cmd_if.sink   cmd,
    tbp_res_if.source res,
    tbp_cfg_if.sink   cfg
);
    import tbp_pkg::*;

    pix_req_t          pix_req;
    pix_rsp_t          pix_rsp;
    logic [WORD_W-1:0] mem_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    tbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg       (cfg),
        .pix_req   (pix_req),
        .pix_rsp   (pix_rsp),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr)
    );

    tbp_pix u_pix (
        .req   (pix_req),
        .rdata (mem_rdata),
        .rsp   (pix_rsp)
    );

    tbp_ram #(
        .DEPTH  (MEM_DEPTH),
        .DATA_W (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
